### sv/mrbw_pkg.sv
package mrbw_pkg;

    localparam int LENGTH_W    = 13;
    localparam int POSITION_W  = 12;
    localparam int FILL_W      = 8;
    localparam int FILL_SHIFT  = 7;

    localparam logic              CMD_BYTE     = 1'b0;
    localparam logic              CMD_SET_READ = 1'b1;
    localparam logic [FILL_W-1:0] FILL_EMPTY   = 8'd0;
    localparam logic [FILL_W-1:0] FILL_FULL    = 8'd128;

    typedef struct packed {
        logic                  command;
        logic [7:0]            data_byte;
        logic [LENGTH_W-1:0]   message_length;
        logic                  first_of_message;
        logic [POSITION_W-1:0] new_read_position;
    } item_t;

    typedef struct packed {
        logic                  message_accepted;
        logic [FILL_W-1:0]     fill_level;
        logic [POSITION_W-1:0] write_position;
    } result_t;

endpackage

### sv/mrbw_stream_if.sv
interface mrbw_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### sv/mrbw_in_stage.sv
module mrbw_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    mrbw_stream_if.sink         items,
    input  logic                advance,
    output logic                item_valid,
    output mrbw_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    mrbw_pkg::item_t item_reg;
    logic            take;

    // stage empties whenever the core moves on, so one request per cycle unless the results are stalled
    assign items.ready = !valid_reg || advance;
    assign take        = items.valid && items.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= items.payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/mrbw_store.sv
module mrbw_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

### sv/mrbw_core.sv
module mrbw_core #(
    parameter int PTR_W = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  mrbw_pkg::item_t     item,
    output logic                advance,
    output logic                wr_en,
    output logic [PTR_W-1:0]    wr_addr,
    output logic [7:0]          wr_data,
    mrbw_stream_if.source       results
);

    localparam int LEN_W = mrbw_pkg::LENGTH_W;
    localparam int POS_W = mrbw_pkg::POSITION_W;
    localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam int EXT_W = (PTR_W > POS_W) ? PTR_W : POS_W;
    localparam int SCL_W = PTR_W + mrbw_pkg::FILL_SHIFT;

    logic [PTR_W-1:0] pw_reg, pw_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wc_reg, wc_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             ok_reg, ok_next;
    logic             out_valid_reg, out_valid_next;
    mrbw_pkg::result_t result_reg, result_next;

    logic             go;
    logic             accepted;
    logic             ok_v;
    logic [PTR_W-1:0] cur;
    logic [LEN_W-1:0] rem;
    logic [PTR_W-1:0] free_now;
    logic [PTR_W-1:0] free_after;
    logic [EXT_W-1:0] rd_ext;
    logic [EXT_W-1:0] wp_ext;
    logic [SCL_W-1:0] scaled;
    logic [mrbw_pkg::FILL_W-1:0] fill;

    assign advance = !out_valid_reg || results.ready;
    assign go      = item_valid && advance;
    assign wr_data = item.data_byte;
    assign rd_ext  = EXT_W'(item.new_read_position);

    // free space is (read - write - 1) mod size, natural wrap of the pointer width
    assign free_now = rp_reg - pw_reg - PTR_W'(1);

    always_comb
    begin
        pw_next  = pw_reg;
        rp_next  = rp_reg;
        wc_next  = wc_reg;
        rem_next = rem_reg;
        ok_next  = ok_reg;
        ok_v     = ok_reg;
        cur      = wc_reg;
        rem      = rem_reg;
        accepted = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = wc_reg;
        if (go)
        begin
            if (item.command == mrbw_pkg::CMD_SET_READ)
            begin
                rp_next = rd_ext[PTR_W-1:0];
            end
            else
            begin
                if (item.first_of_message)
                begin
                    // length + 1 <= free
                    if (CMP_W'(item.message_length) < CMP_W'(free_now))
                    begin
                        ok_v     = 1'b1;
                        cur      = pw_reg;
                        rem      = item.message_length;
                        accepted = 1'b1;
                    end
                    else
                    begin
                        ok_v = 1'b0;
                        rem  = '0;
                    end
                end
                if (ok_v && (rem != '0))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur;
                    cur      = cur + PTR_W'(1);
                    rem      = rem - LEN_W'(1);
                    accepted = 1'b1;
                    // publish only once the last byte is in
                    if (rem == '0)
                    begin
                        pw_next = cur;
                    end
                end
                ok_next  = ok_v;
                wc_next  = cur;
                rem_next = rem;
            end
        end
    end

    // fill level from the state as left by this request
    assign free_after = rp_next - pw_next - PTR_W'(1);
    assign scaled     = {free_after, mrbw_pkg::FILL_SHIFT'(0)} >> PTR_W;
    assign wp_ext     = EXT_W'(pw_next);

    always_comb
    begin
        if (pw_next == rp_next)
        begin
            fill = mrbw_pkg::FILL_EMPTY;
        end
        else
        begin
            fill = mrbw_pkg::FILL_FULL - mrbw_pkg::FILL_W'(scaled);
        end
    end

    always_comb
    begin
        result_next                  = result_reg;
        out_valid_next               = out_valid_reg;
        if (go)
        begin
            result_next.message_accepted = accepted;
            result_next.fill_level       = fill;
            result_next.write_position   = wp_ext[POS_W-1:0];
            out_valid_next               = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg        <= '0;
            rp_reg        <= '0;
            wc_reg        <= '0;
            rem_reg       <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pw_reg        <= pw_next;
            rp_reg        <= rp_next;
            wc_reg        <= wc_next;
            rem_reg       <= rem_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = result_reg;

endmodule

### sv/message_ring_buffer_writer.sv
// Byte ring buffer that stores whole messages or none of them. A request is either a message
// byte (the first one carries the length, and the message is taken only if length + 1 fits in
// the free space) or a new read position from the reader. Every request gives one result with
// the accepted flag, the fill level scaled 0 (empty) to 128 (full) and the published write
// position, which moves only after the last byte of a message. One request is taken every
// cycle unless the result register is stalled. A request goes through an input register, then
// a single pass through the pointer update and fill scaling into the result register.
// RING_DEPTH must be a power of two; positions wrap at the pointer width.
module message_ring_buffer_writer #(
    parameter int RING_DEPTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    mrbw_stream_if.sink   items,
    mrbw_stream_if.source results
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic              advance;
    logic              item_valid;
    mrbw_pkg::item_t   item;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [7:0]        wr_data;

    mrbw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mrbw_core #(
        .PTR_W       (PTR_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .results    (results)
    );

    mrbw_store #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH      = 4096;
    localparam int PIPE_LATENCY    = 2;
    localparam int RANDOM_REQUESTS = 1950;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_WAIT        = 6;
    localparam int MAX_REPORTS     = 30;

    class ring_fill_ledger;
        logic [mrbw_pkg::POSITION_W-1:0] published_write;
        logic [mrbw_pkg::POSITION_W-1:0] read_position;
        logic [mrbw_pkg::POSITION_W-1:0] write_cursor;
        logic [mrbw_pkg::LENGTH_W-1:0]   bytes_left;
        bit                              message_ok;
        mrbw_pkg::result_t               status_due[$];
        int mismatches;
        int checked;
        int noted;
        int useful;
        int taken;
        int refused;
        int full_seen;
        int empty_seen;

        function new();
            published_write = '0;
            read_position   = '0;
            write_cursor    = '0;
            bytes_left      = '0;
            message_ok      = 1'b0;
        endfunction

        function int free_bytes();
            logic [mrbw_pkg::POSITION_W-1:0] gap;
            gap = read_position - published_write - 1'b1;
            return int'(gap);
        endfunction

        function void note_request(mrbw_pkg::item_t req);
            mrbw_pkg::result_t status;
            int                scaled;
            noted++;
            status.message_accepted = 1'b0;
            if (req.command == mrbw_pkg::CMD_SET_READ)
            begin
                read_position = req.new_read_position;
                useful++;
            end
            else
            begin
                if (req.first_of_message)
                begin
                    useful++;
                    if (int'(req.message_length) + 1 <= free_bytes())
                    begin
                        message_ok              = 1'b1;
                        write_cursor            = published_write;
                        bytes_left              = req.message_length;
                        status.message_accepted = 1'b1;
                        taken++;
                    end
                    else
                    begin
                        message_ok = 1'b0;
                        bytes_left = '0;
                        refused++;
                    end
                end
                if (message_ok && bytes_left != 0)
                begin
                    write_cursor = write_cursor + 1'b1;
                    bytes_left   = bytes_left - 1'b1;
                    if (bytes_left == 0)
                        published_write = write_cursor;
                    status.message_accepted = 1'b1;
                    if (!req.first_of_message)
                        useful++;
                end
            end
            if (published_write == read_position)
            begin
                status.fill_level = mrbw_pkg::FILL_EMPTY;
                empty_seen++;
            end
            else
            begin
                scaled = int'(mrbw_pkg::FILL_FULL)
                         - (free_bytes() << mrbw_pkg::FILL_SHIFT) / RING_DEPTH;
                status.fill_level = mrbw_pkg::FILL_W'(scaled);
                if (status.fill_level == mrbw_pkg::FILL_FULL)
                    full_seen++;
            end
            status.write_position = published_write;
            status_due.push_back(status);
        endfunction

        function void flag(string what, int want, int seen);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
        endfunction

        function void check_result(mrbw_pkg::result_t seen);
            mrbw_pkg::result_t want;
            checked++;
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected, got accepted %0b fill %0d write %0d",
                             $time, seen.message_accepted, seen.fill_level,
                             seen.write_position);
                return;
            end
            want = status_due.pop_front();
            if (seen.message_accepted !== want.message_accepted)
                flag("message_accepted", int'(want.message_accepted),
                     int'(seen.message_accepted));
            if (seen.fill_level !== want.fill_level)
                flag("fill_level", int'(want.fill_level), int'(seen.fill_level));
            if (seen.write_position !== want.write_position)
                flag("write_position", int'(want.write_position), int'(seen.write_position));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   send_burst  = 0;
    int   sink_burst  = 0;

    ring_fill_ledger ledger = new();

    mrbw_stream_if #(.payload_t(mrbw_pkg::item_t))   req_if ();
    mrbw_stream_if #(.payload_t(mrbw_pkg::result_t)) res_if ();

    message_ring_buffer_writer #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (req_if),
        .results(res_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            ledger.note_request(req_if.payload);
        if (rst_n && res_if.valid && res_if.ready)
            ledger.check_result(res_if.payload);
    end

    // mostly random waits, with occasional back-to-back stretches
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_request(mrbw_pkg::item_t req);
        int pause;
        pause = draw_wait(send_burst);
        if (pause > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        req_if.payload <= req;
        req_if.valid   <= 1'b1;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic send_byte(bit first, logic [mrbw_pkg::LENGTH_W-1:0] len, logic [7:0] data);
        mrbw_pkg::item_t req;
        req.command           = mrbw_pkg::CMD_BYTE;
        req.data_byte         = data;
        req.message_length    = len;
        req.first_of_message  = first;
        req.new_read_position = mrbw_pkg::POSITION_W'($urandom);
        send_request(req);
    endtask

    task automatic set_read(logic [mrbw_pkg::POSITION_W-1:0] pos);
        mrbw_pkg::item_t req;
        req.command           = mrbw_pkg::CMD_SET_READ;
        req.data_byte         = 8'($urandom);
        req.message_length    = mrbw_pkg::LENGTH_W'($urandom);
        req.first_of_message  = 1'($urandom);
        req.new_read_position = pos;
        send_request(req);
    endtask

    task automatic move_reader();
        logic [mrbw_pkg::POSITION_W-1:0] used;
        logic [mrbw_pkg::POSITION_W-1:0] pos;
        int                              pick;
        pick = $urandom_range(0, 9);
        used = ledger.published_write - ledger.read_position;
        case (pick)
            0: pos = ledger.published_write;
            1: pos = ledger.published_write + 1'b1;
            2, 3: pos = mrbw_pkg::POSITION_W'($urandom);
            default: pos = ledger.read_position
                           + mrbw_pkg::POSITION_W'($urandom_range(0, used));
        endcase
        set_read(pos);
    endtask

    task automatic send_message();
        int pick;
        int len;
        int count;
        int free;
        pick = $urandom_range(0, 15);
        free = ledger.free_bytes();
        if (pick == 0)
            len = 0;
        else if (pick <= 11)
            len = $urandom_range(1, 16);
        else if (pick <= 13)
            len = $urandom_range(17, 200);
        else if (pick == 14)
            len = (free == 0) ? 0 : free - 1 + $urandom_range(0, 1);
        else
            len = $urandom_range(0, 8191);
        count = (len == 0) ? 1 : len;
        // very long messages get cut short, a few ordinary ones too
        if (count > 200)
            count = $urandom_range(1, 40);
        else if ($urandom_range(0, 19) == 0)
            count = $urandom_range(1, count);
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && $urandom_range(0, 29) == 0)
                move_reader();
            send_byte(i == 0, mrbw_pkg::LENGTH_W'(len), 8'($urandom));
        end
    endtask

    initial
    begin
        int pause;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            pause = draw_wait(sink_burst);
            if (pause > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int kind;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_byte(1'b0, 13'd5, 8'hFF);      // stray byte on an empty buffer
        send_byte(1'b1, 13'd0, 8'h00);      // zero-length message
        send_byte(1'b1, 13'd3, 8'h00);
        send_byte(1'b0, 13'd3, 8'hFF);
        send_byte(1'b0, 13'd3, 8'hA5);
        set_read(12'hFFF);                  // almost empty, lowest nonzero fill
        set_read(12'd4);                    // reader just ahead of writer: full
        send_byte(1'b1, 13'd0, 8'h11);      // even an empty message is refused
        send_byte(1'b0, 13'd1, 8'h22);      // tail of a refused message is dropped
        set_read(12'd3);
        send_byte(1'b1, 13'd4095, 8'h33);   // one past the free space
        send_byte(1'b1, 13'd4096, 8'h44);
        send_byte(1'b1, 13'd8191, 8'h55);
        send_byte(1'b1, 13'd4094, 8'h5A);   // fits exactly
        send_byte(1'b0, 13'd0, 8'hC3);
        send_byte(1'b1, 13'd2, 8'h01);      // restart abandons the long message
        set_read(12'd0);                    // reader moves mid-message
        send_byte(1'b0, 13'd2, 8'h02);
        send_byte(1'b0, 13'd2, 8'h03);      // stray after completion

        while (ledger.noted < RANDOM_REQUESTS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
                move_reader();
            else if (kind < 90)
                send_message();
            else
                repeat ($urandom_range(1, 4))
                    send_byte(1'b0, mrbw_pkg::LENGTH_W'($urandom), 8'($urandom));
        end
        req_if.valid <= 1'b0;

        while (ledger.status_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("%0d requests that mattered, %0d messages taken, %0d refused, %0d results checked",
                 ledger.useful, ledger.taken, ledger.refused, ledger.checked);
        $display("fill level reported full %0d times and empty %0d times",
                 ledger.full_seen, ledger.empty_seen);
        if (ledger.mismatches == 0 && ledger.status_due.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     ledger.mismatches, ledger.status_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/mrbw_pkg.sv
sv/mrbw_stream_if.sv
sv/mrbw_in_stage.sv
sv/mrbw_store.sv
sv/mrbw_core.sv
sv/message_ring_buffer_writer.sv
bench/tb_top.sv
